>>> hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/p2pl_pkg.sv
// ----------------------------------------------------------------------------
// p2pl_pkg
// Register indexes, widths and arithmetic helpers of the point-to-plane unit.
// ----------------------------------------------------------------------------
`default_nettype none

package p2pl_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 63;
  localparam int unsigned NumStg   = 6;

  localparam logic [CfgIdxW-1:0] RegBodyRot0  = 4'd0;
  localparam logic [CfgIdxW-1:0] RegBodyRot1  = 4'd1;
  localparam logic [CfgIdxW-1:0] RegBodyRot2  = 4'd2;
  localparam logic [CfgIdxW-1:0] RegBodyTrans = 4'd3;
  localparam logic [CfgIdxW-1:0] RegLidRot0   = 4'd4;
  localparam logic [CfgIdxW-1:0] RegLidRot1   = 4'd5;
  localparam logic [CfgIdxW-1:0] RegLidRot2   = 4'd6;
  localparam logic [CfgIdxW-1:0] RegLidTrans  = 4'd7;

  localparam logic [47:0] RotRow0Rst = 48'd16384;
  localparam logic [47:0] RotRow1Rst = 48'd1073741824;
  localparam logic [47:0] RotRow2Rst = 48'd70368744177664;

  // round to nearest (ties up) dropping 14 fraction bits, then clamp to 24 bits
  function automatic logic signed [23:0] rnd_sat24(input logic signed [52:0] x);
    logic signed [52:0] t;
    t = (x + 53'sd8192) >>> 14;
    if (t > 53'sd8388607) begin
      return 24'sh7fffff;
    end else if (t < -53'sd8388608) begin
      return 24'sh800000;
    end else begin
      return t[23:0];
    end
  endfunction

  function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] x);
    if (x == 16'sh8000) begin
      return 16'sh7fff;
    end else begin
      return -x;
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/point_to_plane_residual_jacobian_top.sv
// ----------------------------------------------------------------------------
// point_to_plane_residual_jacobian_top
// Residual and Jacobian of one point-to-plane correspondence per cycle when unstalled.
// ----------------------------------------------------------------------------
// Input channel in_valid_i / in_stall_o carries one correspondence request:
// mode, point, normal and plane offset. Output channel out_valid_o /
// out_stall_i returns the residual, rotation Jacobian and position Jacobian.
// Poses are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must
// write them only while idle, which the block does not enforce. Indexes above
// 7 are dropped. Requests reach out_valid_o through the six-stage multiply
// pipeline (extrinsic transform, pose transform, normal dot product).
// Throughput is one request per cycle while the receiver does not stall a waiting result.
// Reset clears all stage valid bits and loads identity rotations and zero
// translations. When the receiver stalls with a result waiting, the whole
// pipeline holds and in_stall_o rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module point_to_plane_residual_jacobian_top (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire [p2pl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [p2pl_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire                        mode_i,
  input  wire signed [20:0]          point_x_i,
  input  wire signed [20:0]          point_y_i,
  input  wire signed [20:0]          point_z_i,
  input  wire signed [15:0]          normal_x_i,
  input  wire signed [15:0]          normal_y_i,
  input  wire signed [15:0]          normal_z_i,
  input  wire signed [20:0]          plane_offset_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic signed [23:0]         residual_o,
  output logic signed [23:0]         rot_jac_x_o,
  output logic signed [23:0]         rot_jac_y_o,
  output logic signed [23:0]         rot_jac_z_o,
  output logic signed [15:0]         pos_jac_x_o,
  output logic signed [15:0]         pos_jac_y_o,
  output logic signed [15:0]         pos_jac_z_o
);

  localparam int unsigned NS = p2pl_pkg::NumStg;

  logic [47:0] brot_q [3];
  logic [62:0] btr_q;
  logic [47:0] lrot_q [3];
  logic [62:0] ltr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brot_q[0] <= p2pl_pkg::RotRow0Rst;
      brot_q[1] <= p2pl_pkg::RotRow1Rst;
      brot_q[2] <= p2pl_pkg::RotRow2Rst;
      lrot_q[0] <= p2pl_pkg::RotRow0Rst;
      lrot_q[1] <= p2pl_pkg::RotRow1Rst;
      lrot_q[2] <= p2pl_pkg::RotRow2Rst;
      btr_q     <= '0;
      ltr_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        p2pl_pkg::RegBodyRot0:  brot_q[0] <= cfg_data_i[47:0];
        p2pl_pkg::RegBodyRot1:  brot_q[1] <= cfg_data_i[47:0];
        p2pl_pkg::RegBodyRot2:  brot_q[2] <= cfg_data_i[47:0];
        p2pl_pkg::RegBodyTrans: btr_q     <= cfg_data_i;
        p2pl_pkg::RegLidRot0:   lrot_q[0] <= cfg_data_i[47:0];
        p2pl_pkg::RegLidRot1:   lrot_q[1] <= cfg_data_i[47:0];
        p2pl_pkg::RegLidRot2:   lrot_q[2] <= cfg_data_i[47:0];
        p2pl_pkg::RegLidTrans:  ltr_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [15:0] rb [3][3];
  logic signed [15:0] rl [3][3];
  logic signed [20:0] tb [3];
  logic signed [20:0] tl [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rb[i][j] = brot_q[i][16*j +: 16];
        rl[i][j] = lrot_q[i][16*j +: 16];
      end
      tb[i] = btr_q[21*i +: 21];
      tl[i] = ltr_q[21*i +: 21];
    end
  end

  // pipeline control
  logic [NS-1:0] v_q;
  logic          adv;

  assign adv        = !(v_q[NS-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  // stage 1: extrinsic and transposed-pose products
  logic signed [39:0] lsum_d [3];
  logic signed [34:0] csum_d [3];
  logic signed [39:0] lsum_q [3];
  logic signed [34:0] csum_q [3];
  logic signed [20:0] p1_q [3];
  logic               mode1_q;
  logic signed [15:0] n1_q [3];
  logic signed [20:0] d1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lsum_d[i] = 40'(rl[i][0] * point_x_i) + 40'(rl[i][1] * point_y_i)
                + 40'(rl[i][2] * point_z_i);
      csum_d[i] = 35'(rb[0][i] * normal_x_i) + 35'(rb[1][i] * normal_y_i)
                + 35'(rb[2][i] * normal_z_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lsum_q  <= lsum_d;
      csum_q  <= csum_d;
      p1_q[0] <= point_x_i;
      p1_q[1] <= point_y_i;
      p1_q[2] <= point_z_i;
      mode1_q <= mode_i;
      n1_q[0] <= normal_x_i;
      n1_q[1] <= normal_y_i;
      n1_q[2] <= normal_z_i;
      d1_q    <= plane_offset_i;
    end
  end

  // stage 2: body point and rounded c
  logic signed [26:0] pb2_q [3];
  logic signed [20:0] c2_q [3];
  logic signed [15:0] n2_q [3];
  logic signed [20:0] d2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (mode1_q) begin
          pb2_q[i] <= 27'(p1_q[i]);
        end else begin
          pb2_q[i] <= 27'((lsum_q[i] + 40'sd8192) >>> 14) + 27'(tl[i]);
        end
        c2_q[i] <= 21'((csum_q[i] + 35'sd8192) >>> 14);
      end
      n2_q <= n1_q;
      d2_q <= d1_q;
    end
  end

  // stage 3: pose products and cross-product terms
  logic signed [45:0] wsum_q [3];
  logic signed [47:0] jp_q [6];
  logic signed [15:0] n3_q [3];
  logic signed [20:0] d3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        wsum_q[i] <= 46'(rb[i][0] * pb2_q[0]) + 46'(rb[i][1] * pb2_q[1])
                   + 46'(rb[i][2] * pb2_q[2]);
      end
      jp_q[0] <= 48'(c2_q[1] * pb2_q[2]);
      jp_q[1] <= 48'(c2_q[2] * pb2_q[1]);
      jp_q[2] <= 48'(c2_q[2] * pb2_q[0]);
      jp_q[3] <= 48'(c2_q[0] * pb2_q[2]);
      jp_q[4] <= 48'(c2_q[0] * pb2_q[1]);
      jp_q[5] <= 48'(c2_q[1] * pb2_q[0]);
      n3_q <= n2_q;
      d3_q <= d2_q;
    end
  end

  // stage 4: world point and rotation jacobian
  logic signed [32:0] pw4_q [3];
  logic signed [23:0] jr4_q [3];
  logic signed [15:0] n4_q [3];
  logic signed [20:0] d4_q;
  logic signed [23:0] jr5_q [3];
  logic signed [15:0] n5_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pw4_q[i] <= 33'((wsum_q[i] + 46'sd8192) >>> 14) + 33'(tb[i]);
        jr4_q[i] <= p2pl_pkg::rnd_sat24(53'(jp_q[2*i]) - 53'(jp_q[2*i+1]));
      end
      n4_q <= n3_q;
      d4_q <= d3_q;
    end
  end

  // stage 5: plane distance accumulate
  logic signed [52:0] acc5_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      acc5_q <= (53'(d4_q) <<< 14)
              - (53'(n4_q[0] * pw4_q[0]) + 53'(n4_q[1] * pw4_q[1])
               + 53'(n4_q[2] * pw4_q[2]));
      jr5_q <= jr4_q;
      n5_q  <= n4_q;
    end
  end

  // stage 6: output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      residual_o  <= p2pl_pkg::rnd_sat24(acc5_q);
      rot_jac_x_o <= jr5_q[0];
      rot_jac_y_o <= jr5_q[1];
      rot_jac_z_o <= jr5_q[2];
      pos_jac_x_o <= p2pl_pkg::neg_sat16(n5_q[0]);
      pos_jac_y_o <= p2pl_pkg::neg_sat16(n5_q[1]);
      pos_jac_z_o <= p2pl_pkg::neg_sat16(n5_q[2]);
    end
  end

  assign out_valid_o = v_q[NS-1];

  `ASSERT_IMPL(a_stall_needs_result, clk_i, rst_ni, in_stall_o, out_valid_o)
  `ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_valid_i && !in_stall_o, v_q[0])
  `ASSERT_IMPL(a_posjac_sat, clk_i, rst_ni, out_valid_o, pos_jac_x_o != 16'sh8000)

endmodule

`default_nettype wire
